### hw/rtl/ngad_pkg.sv
// Shared types, constants and helpers for the nucleotide global alignment core.
// No dependencies; imported by every module in hw/rtl.
`default_nettype none
package ngad_pkg;

   localparam int MAX_LEN     = 32;
   localparam int DIM         = MAX_LEN + 1;
   localparam int TABLE_DEPTH = DIM * DIM;
   localparam int IDX_W       = $clog2(MAX_LEN);
   localparam int LEN_W       = $clog2(MAX_LEN + 1);
   localparam int CNT_W       = $clog2(DIM + 1);
   localparam int ADDR_W      = $clog2(TABLE_DEPTH + DIM + 1);
   localparam int COST_W      = 24;
   localparam int PEN_W       = 16;

   typedef logic signed [COST_W-1:0] cost_type;
   typedef logic signed [PEN_W-1:0]  pen_type;

   localparam cost_type MATCH_SCORE = -24'sd256;

   localparam pen_type MISMATCH_RESET = 16'sd256;
   localparam pen_type GAP_RESET      = 16'sd512;
   localparam pen_type SKEW_RESET     = 16'sd0;

   // input modes
   localparam logic [1:0] MODE_LOAD_A = 2'd0;
   localparam logic [1:0] MODE_LOAD_B = 2'd1;
   localparam logic [1:0] MODE_ALIGN  = 2'd2;

   // edit actions
   localparam logic [1:0] ACT_REPLACE = 2'd0;
   localparam logic [1:0] ACT_DELETE  = 2'd1;
   localparam logic [1:0] ACT_INSERT  = 2'd2;
   localparam logic [1:0] ACT_NONE    = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_MISMATCH = 2'd0;
   localparam logic [1:0] CSR_GAP      = 2'd1;
   localparam logic [1:0] CSR_SKEW     = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] symbol;
   } req_type;

   typedef struct packed {
      logic signed [5:0] position;
      logic [1:0]        base;
      logic [1:0]        action;
      logic              last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_COL,
      ST_ROW,
      ST_FILL_START,
      ST_FILL_RD,
      ST_FILL_WR,
      ST_TB_START,
      ST_TB_UP,
      ST_TB_LEFT,
      ST_TB_DIAG,
      ST_TB_DEC,
      ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      CMD_NOP,
      CMD_LOAD,
      CMD_INIT0,
      CMD_COLA,
      CMD_ROWB,
      CMD_FILL_START,
      CMD_FILL_RD,
      CMD_FILL_WR,
      CMD_TB_START,
      CMD_TB_UP,
      CMD_TB_LEFT,
      CMD_TB_DIAG,
      CMD_TB_DEC,
      CMD_FINISH
   } cmd_type;

   typedef struct packed {
      logic i_end;
      logic j_end;
      logic origin;
      logic a_empty;
      logic b_empty;
   } stat_type;

   function automatic logic [1:0] base_code(input logic [7:0] s);
      logic [1:0] c;
      unique case (s)
         8'd1, 8'h43, 8'h63: c = 2'd1;
         8'd2, 8'h47, 8'h67: c = 2'd2;
         8'd3, 8'h54, 8'h74: c = 2'd3;
         default:            c = 2'd0;
      endcase
      return c;
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [CNT_W-1:0] i,
                                                   input logic [CNT_W-1:0] j);
      logic [ADDR_W-1:0] a;
      a = ADDR_W'(i) * ADDR_W'(DIM) + ADDR_W'(j);
      return a;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/ngad_ctrl.sv
// Sequencing state machine: load, table init, fill and traceback phases.
// Depends on ngad_pkg; drives the datapath through cmd_type commands.
`default_nettype none
module ngad_ctrl
   import ngad_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire req_type  req_item,
   input  wire stat_type status,
   output cmd_type       cmd,
   output logic          busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start && req_item.mode == MODE_ALIGN) state_in = ST_INIT;
         end
         ST_INIT:       state_in = ST_COL;
         ST_COL: begin
            if (status.i_end) state_in = ST_ROW;
         end
         ST_ROW: begin
            if (status.j_end) begin
               if (status.a_empty || status.b_empty) state_in = ST_TB_START;
               else                                   state_in = ST_FILL_START;
            end
         end
         ST_FILL_START: state_in = ST_FILL_RD;
         ST_FILL_RD:    state_in = ST_FILL_WR;
         ST_FILL_WR: begin
            if (status.i_end && status.j_end) state_in = ST_TB_START;
            else                              state_in = ST_FILL_RD;
         end
         ST_TB_START:   state_in = ST_TB_UP;
         ST_TB_UP: begin
            if (status.origin) state_in = ST_DONE;
            else               state_in = ST_TB_LEFT;
         end
         ST_TB_LEFT:    state_in = ST_TB_DIAG;
         ST_TB_DIAG:    state_in = ST_TB_DEC;
         ST_TB_DEC:     state_in = ST_TB_UP;
         ST_DONE:       state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = CMD_NOP;
      busy = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (start && (req_item.mode == MODE_LOAD_A || req_item.mode == MODE_LOAD_B))
               cmd = CMD_LOAD;
         end
         ST_INIT:       cmd = CMD_INIT0;
         ST_COL:        cmd = status.i_end ? CMD_NOP : CMD_COLA;
         ST_ROW:        cmd = status.j_end ? CMD_NOP : CMD_ROWB;
         ST_FILL_START: cmd = CMD_FILL_START;
         ST_FILL_RD:    cmd = CMD_FILL_RD;
         ST_FILL_WR:    cmd = CMD_FILL_WR;
         ST_TB_START:   cmd = CMD_TB_START;
         ST_TB_UP:      cmd = status.origin ? CMD_NOP : CMD_TB_UP;
         ST_TB_LEFT:    cmd = CMD_TB_LEFT;
         ST_TB_DIAG:    cmd = CMD_TB_DIAG;
         ST_TB_DEC:     cmd = CMD_TB_DEC;
         ST_DONE:       cmd = CMD_FINISH;
         default:       cmd = CMD_NOP;
      endcase
   end

   // fill alternates read and write cycles
   a_fill_alt: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FILL_RD |=> state_ff == ST_FILL_WR)
      else $error("fill read not followed by write");

   // a traceback step always runs its three reads in order
   a_tb_seq: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TB_LEFT |=> state_ff == ST_TB_DIAG ##1 state_ff == ST_TB_DEC)
      else $error("traceback read sequence broken");

   // an align run ends in the idle state
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> state_ff == ST_IDLE)
      else $error("done not followed by idle");

endmodule
`default_nettype wire

### hw/rtl/ngad_dp.sv
// Datapath: sequence stores, penalty registers, cost table memory, traceback.
// Depends on ngad_pkg; controlled by ngad_ctrl through cmd_type commands.
`default_nettype none
module ngad_dp
   import ngad_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   input  wire req_type     req_item,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata,
   output stat_type         status,
   output logic             rsp_valid,
   output rsp_type          rsp_item
);

   logic [1:0]       seq_a_ff [MAX_LEN];
   logic [1:0]       seq_b_ff [MAX_LEN];
   logic [LEN_W-1:0] len_a_ff, len_a_in, len_b_ff, len_b_in;
   pen_type          mism_ff, mism_in, gap_ff, gap_in, skew_ff, skew_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in;
   cost_type         col_ff, col_in, row_ff, row_in;
   cost_type         left_ff, left_in, diag_ff, diag_in;
   cost_type         dn_ff, dn_in, rt_ff, rt_in;
   rsp_type          pend_ff, pend_in, rsp_ff, rsp_in;
   logic             pend_vld_ff, pend_vld_in, rsp_vld_ff, rsp_vld_in;

   cost_type          cost_mem [TABLE_DEPTH];
   cost_type          rdata_ff;
   logic [ADDR_W-1:0] rd_addr, wr_addr;
   logic              wr_en;
   cost_type          wr_data;

   // shared terms
   logic [CNT_W-1:0] i_m1, j_m1;
   logic [IDX_W-1:0] a_idx, b_idx;
   logic [1:0]       a_base, b_base;
   cost_type         mism_x, gap_x, skew_x, pen_dn, pen_rt, pair_c;
   cost_type         f_dn, f_rt, f_dg, f_m, f_cell, t_dg;
   logic             a_load, b_load, take_dg, take_del, i_nz, j_nz;

   assign i_m1   = i_ff - CNT_W'(1);
   assign j_m1   = j_ff - CNT_W'(1);
   assign a_idx  = i_m1[IDX_W-1:0];
   assign b_idx  = j_m1[IDX_W-1:0];
   assign a_base = seq_a_ff[a_idx];
   assign b_base = seq_b_ff[b_idx];
   assign mism_x = COST_W'(mism_ff);
   assign gap_x  = COST_W'(gap_ff);
   assign skew_x = COST_W'(skew_ff);
   assign pen_dn = (j_ff == CNT_W'(len_b_ff)) ? skew_x : gap_x;
   assign pen_rt = (i_ff == CNT_W'(len_a_ff)) ? skew_x : gap_x;
   assign pair_c = (a_base == b_base) ? MATCH_SCORE : mism_x;
   assign i_nz   = (i_ff != '0);
   assign j_nz   = (j_ff != '0);

   // fill cell: up comes from memory, left and diag from registers
   assign f_dn   = rdata_ff + pen_dn;
   assign f_rt   = left_ff + pen_rt;
   assign f_dg   = diag_ff + pair_c;
   assign f_m    = (f_dn < f_rt) ? f_dn : f_rt;
   assign f_cell = (f_dg < f_m) ? f_dg : f_m;

   // traceback decision
   assign t_dg     = rdata_ff + pair_c;
   assign take_dg  = i_nz && j_nz && (t_dg <= dn_ff) && (t_dg <= rt_ff);
   assign take_del = !take_dg && i_nz && (!j_nz || dn_ff < rt_ff);

   assign a_load = (cmd == CMD_LOAD) && (req_item.mode == MODE_LOAD_A)
                   && (len_a_ff < LEN_W'(MAX_LEN));
   assign b_load = (cmd == CMD_LOAD) && (req_item.mode == MODE_LOAD_B)
                   && (len_b_ff < LEN_W'(MAX_LEN));

   // memory port selection
   always_comb begin
      rd_addr = '0;
      wr_addr = '0;
      wr_en   = 1'b0;
      wr_data = '0;
      case (cmd)
         CMD_INIT0: begin
            wr_en = 1'b1;
         end
         CMD_COLA: begin
            wr_en   = 1'b1;
            wr_addr = cell_addr(i_ff + CNT_W'(1), '0);
            wr_data = col_ff + skew_x;
         end
         CMD_ROWB: begin
            wr_en   = 1'b1;
            wr_addr = cell_addr('0, j_ff + CNT_W'(1));
            wr_data = row_ff + skew_x;
         end
         CMD_FILL_RD: rd_addr = cell_addr(i_m1, j_ff);
         CMD_FILL_WR: begin
            wr_en   = 1'b1;
            wr_addr = cell_addr(i_ff, j_ff);
            wr_data = f_cell;
         end
         CMD_TB_UP:   if (i_nz) rd_addr = cell_addr(i_m1, j_ff);
         CMD_TB_LEFT: if (j_nz) rd_addr = cell_addr(i_ff, j_m1);
         CMD_TB_DIAG: if (i_nz && j_nz) rd_addr = cell_addr(i_m1, j_m1);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) cost_mem[wr_addr] <= wr_data;
      rdata_ff <= cost_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (a_load) seq_a_ff[len_a_ff[IDX_W-1:0]] <= base_code(req_item.symbol);
      if (b_load) seq_b_ff[len_b_ff[IDX_W-1:0]] <= base_code(req_item.symbol);
   end

   always_comb begin
      len_a_in    = len_a_ff;
      len_b_in    = len_b_ff;
      mism_in     = mism_ff;
      gap_in      = gap_ff;
      skew_in     = skew_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      left_in     = left_ff;
      diag_in     = diag_ff;
      dn_in       = dn_ff;
      rt_in       = rt_ff;
      pend_in     = pend_ff;
      pend_vld_in = pend_vld_ff;
      rsp_in      = rsp_ff;
      rsp_vld_in  = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_MISMATCH: mism_in = csr_wdata;
            CSR_GAP:      gap_in  = csr_wdata;
            CSR_SKEW:     skew_in = csr_wdata;
            default: ;
         endcase
      end

      if (a_load) len_a_in = len_a_ff + LEN_W'(1);
      if (b_load) len_b_in = len_b_ff + LEN_W'(1);

      case (cmd)
         CMD_INIT0: begin
            i_in   = '0;
            j_in   = '0;
            col_in = '0;
            row_in = '0;
         end
         CMD_COLA: begin
            i_in   = i_ff + CNT_W'(1);
            col_in = col_ff + skew_x;
         end
         CMD_ROWB: begin
            j_in   = j_ff + CNT_W'(1);
            row_in = row_ff + skew_x;
         end
         CMD_FILL_START: begin
            i_in    = CNT_W'(1);
            j_in    = CNT_W'(1);
            diag_in = '0;
            left_in = skew_x;
            col_in  = skew_x;
         end
         CMD_FILL_WR: begin
            if (j_ff == CNT_W'(len_b_ff)) begin
               i_in    = i_ff + CNT_W'(1);
               j_in    = CNT_W'(1);
               diag_in = col_ff;
               left_in = col_ff + skew_x;
               col_in  = col_ff + skew_x;
            end else begin
               j_in    = j_ff + CNT_W'(1);
               left_in = f_cell;
               diag_in = rdata_ff;
            end
         end
         CMD_TB_START: begin
            i_in        = CNT_W'(len_a_ff);
            j_in        = CNT_W'(len_b_ff);
            pend_vld_in = 1'b0;
         end
         CMD_TB_LEFT: dn_in = rdata_ff + pen_dn;
         CMD_TB_DIAG: rt_in = rdata_ff + pen_rt;
         CMD_TB_DEC: begin
            if (take_dg) begin
               i_in = i_m1;
               j_in = j_m1;
               if (a_base != b_base) begin
                  rsp_vld_in  = pend_vld_ff;
                  rsp_in      = pend_ff;
                  pend_vld_in = 1'b1;
                  pend_in     = '{position: 6'(i_m1), base: b_base,
                                  action: ACT_REPLACE, last: 1'b0};
               end
            end else if (take_del) begin
               i_in        = i_m1;
               rsp_vld_in  = pend_vld_ff;
               rsp_in      = pend_ff;
               pend_vld_in = 1'b1;
               pend_in     = '{position: 6'(i_m1), base: 2'd0,
                               action: ACT_DELETE, last: 1'b0};
            end else begin
               j_in = j_m1;
               // inserts past the end of A are skew and stay silent
               if (i_ff != CNT_W'(len_a_ff)) begin
                  rsp_vld_in  = pend_vld_ff;
                  rsp_in      = pend_ff;
                  pend_vld_in = 1'b1;
                  pend_in     = '{position: 6'(i_m1), base: b_base,
                                  action: ACT_INSERT, last: 1'b0};
               end
            end
         end
         CMD_FINISH: begin
            rsp_vld_in = 1'b1;
            if (pend_vld_ff) begin
               rsp_in      = pend_ff;
               rsp_in.last = 1'b1;
            end else begin
               rsp_in = '{position: 6'sd0, base: 2'd0, action: ACT_NONE, last: 1'b1};
            end
            pend_vld_in = 1'b0;
            len_a_in    = '0;
            len_b_in    = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_a_ff    <= '0;
         len_b_ff    <= '0;
         mism_ff     <= MISMATCH_RESET;
         gap_ff      <= GAP_RESET;
         skew_ff     <= SKEW_RESET;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         len_a_ff    <= len_a_in;
         len_b_ff    <= len_b_in;
         mism_ff     <= mism_in;
         gap_ff      <= gap_in;
         skew_ff     <= skew_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      col_ff  <= col_in;
      row_ff  <= row_in;
      left_ff <= left_in;
      diag_ff <= diag_in;
      dn_ff   <= dn_in;
      rt_ff   <= rt_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign status.i_end   = (i_ff == CNT_W'(len_a_ff));
   assign status.j_end   = (j_ff == CNT_W'(len_b_ff));
   assign status.origin  = !i_nz && !j_nz;
   assign status.a_empty = (len_a_ff == '0);
   assign status.b_empty = (len_b_ff == '0);

   assign rsp_valid = rsp_vld_ff;
   assign rsp_item  = rsp_ff;

   a_len_a: assert property (@(posedge clock) disable iff (reset)
      len_a_ff <= LEN_W'(MAX_LEN) && len_b_ff <= LEN_W'(MAX_LEN))
      else $error("sequence length past capacity");

   a_none_last: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_ff.action == ACT_NONE |-> rsp_ff.last)
      else $error("none result without last");

   a_finish: assert property (@(posedge clock) disable iff (reset)
      cmd == CMD_FINISH |=> rsp_vld_ff && rsp_ff.last && len_a_ff == '0)
      else $error("finish did not close the run");

endmodule
`default_nettype wire

### hw/rtl/nucleotide_global_alignment_delta_core.sv
// Top level of the nucleotide global alignment edit core.
// Depends on ngad_pkg, ngad_ctrl and ngad_dp.
`default_nettype none
// Usage:
//  - Items enter on req_item when start is high and busy is low.
//    mode 0/1 appends one base to A/B (up to 32 each, extras dropped);
//    a load leaves busy low, so loads stream back to back.
//  - mode 2 runs the alignment. busy rises the next cycle and stays high
//    until the run is over. With la/lb the sequence lengths, the run seeds
//    the table edges, fills the la*lb cells (one cost-table read and one
//    write per cell on a single memory), then walks back with at most
//    la + lb traceback steps of three table reads plus the decision,
//    between a traceback start and close.
//  - Edits come out in reverse order on rsp_item with rsp_valid high for
//    one cycle each; one edit is held back so the final one can carry
//    last. The receiver cannot stall; rsp_valid must be taken as it comes.
//    A run with no edits gives one none item with last set.
//  - csr_we/csr_index/csr_wdata write the mismatch, gap and skew penalties
//    (signed Q8.8) while idle.
//  - Synchronous reset empties both sequences, restores penalties to
//    256/512/0 and returns to idle. The cost table needs no clearing.
module nucleotide_global_alignment_delta_core
   import ngad_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire req_type     req_item,
   output logic             rsp_valid,
   output rsp_type          rsp_item,
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   cmd_type  cmd;
   stat_type status;
   logic     ctrl_busy;

   ngad_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .status   (status),
      .cmd      (cmd),
      .busy     (ctrl_busy)
   );

   ngad_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign busy = ctrl_busy;

endmodule
`default_nettype wire

### sim/nucleotide_global_alignment_delta_core_tb.sv
// Self-checking testbench for nucleotide_global_alignment_delta_core.
// Loads sequences, runs alignments and checks every edit against an in-bench predictor.
// Depends on ngad_pkg and the core RTL.
`timescale 1ns / 1ps
module nucleotide_global_alignment_delta_core_tb;
   import ngad_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;
   localparam int TAIL_ITEMS     = 40;
   localparam int ITEM_TARGET    = 270;
   localparam int NO_PATH        = 32'h7fffffff;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   req_type     req_item = '0;
   logic        rsp_valid;
   rsp_type     rsp_item;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_MISMATCH;
   logic [15:0] csr_wdata = '0;

   nucleotide_global_alignment_delta_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #4 clock = ~clock;

   // predictor state
   logic [1:0] bases_a [MAX_LEN];
   logic [1:0] bases_b [MAX_LEN];
   int         len_a, len_b;
   int         mismatch_pen, gap_pen, skew_pen;
   int         costs [DIM*DIM];

   req_type    pending_items [$];
   rsp_type    expected_edits [$];
   int         error_count = 0;
   int         gap_left = 0;
   int         sent_items = 0;
   int         idle_cycles = 0;

   task automatic report(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [1:0] encode_base(input logic [7:0] s);
      case (s)
         8'd1, "C", "c": return 2'd1;
         8'd2, "G", "g": return 2'd2;
         8'd3, "T", "t": return 2'd3;
         default:        return 2'd0;
      endcase
   endfunction

   task automatic push_edit(input int pos, input logic [1:0] b, input logic [1:0] act);
      rsp_type r;
      r.position = 6'(pos);
      r.base     = b;
      r.action   = act;
      r.last     = 1'b0;
      expected_edits = {expected_edits, r};
   endtask

   // Fills the cost table, walks back from the corner and queues the edits.
   task automatic predict_alignment();
      int i, j, dn, rt, dg, m, n;
      n = 0;
      costs[0] = 0;
      for (i = 1; i <= len_a; i++) costs[i*DIM] = costs[(i-1)*DIM] + skew_pen;
      for (j = 1; j <= len_b; j++) costs[j] = costs[j-1] + skew_pen;
      for (i = 1; i <= len_a; i++)
         for (j = 1; j <= len_b; j++) begin
            dn = costs[(i-1)*DIM+j] + ((j == len_b) ? skew_pen : gap_pen);
            rt = costs[i*DIM+j-1] + ((i == len_a) ? skew_pen : gap_pen);
            dg = costs[(i-1)*DIM+j-1] +
                 ((bases_a[i-1] == bases_b[j-1]) ? int'(MATCH_SCORE) : mismatch_pen);
            m = (dn < rt) ? dn : rt;
            costs[i*DIM+j] = (dg < m) ? dg : m;
         end
      i = len_a;
      j = len_b;
      while (i > 0 || j > 0) begin
         dn = NO_PATH; rt = NO_PATH; dg = NO_PATH;
         if (i > 0) dn = costs[(i-1)*DIM+j] + ((j == len_b) ? skew_pen : gap_pen);
         if (j > 0) rt = costs[i*DIM+j-1] + ((i == len_a) ? skew_pen : gap_pen);
         if (i > 0 && j > 0)
            dg = costs[(i-1)*DIM+j-1] +
                 ((bases_a[i-1] == bases_b[j-1]) ? int'(MATCH_SCORE) : mismatch_pen);
         m = (dn < rt) ? dn : rt;
         if (i > 0 && j > 0 && dg <= m) begin
            if (bases_a[i-1] != bases_b[j-1] && n < 64) begin
               push_edit(i-1, bases_b[j-1], ACT_REPLACE); n++;
            end
            i--; j--;
         end else if (i > 0 && dn < rt) begin
            if (n < 64) begin push_edit(i-1, 2'd0, ACT_DELETE); n++; end
            i--;
         end else begin
            // skew insert: nothing reported once A is used up
            if (i != len_a && n < 64) begin
               push_edit(i-1, bases_b[j-1], ACT_INSERT); n++;
            end
            j--;
         end
      end
      if (n == 0) push_edit(0, 2'd0, ACT_NONE);
      expected_edits[expected_edits.size()-1].last = 1'b1;
      len_a = 0;
      len_b = 0;
   endtask

   task automatic predict_item(input req_type it);
      case (it.mode)
         MODE_LOAD_A: if (len_a < MAX_LEN) begin bases_a[len_a] = encode_base(it.symbol); len_a++; end
         MODE_LOAD_B: if (len_b < MAX_LEN) begin bases_b[len_b] = encode_base(it.symbol); len_b++; end
         MODE_ALIGN:  predict_alignment();
         default: ;  // unknown mode is dropped
      endcase
   endtask

   // driver: holds start until the item is taken, random gaps between items
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) predict_item(req_item);
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_items.size() > 0) begin
               start    <= 1'b1;
               req_item <= pending_items.pop_front();
               sent_items++;
               if (sent_items < ITEM_TARGET - TAIL_ITEMS && $urandom_range(3) == 0)
                  gap_left = $urandom_range(6, 1);
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobe must match the oldest expected edit
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_edits.size() == 0) begin
            report("unexpected edit, action", rsp_item.action, -1);
         end else begin
            want = expected_edits.pop_front();
            if (rsp_item.position != want.position)
               report("position", rsp_item.position, want.position);
            if (rsp_item.base != want.base) report("base", rsp_item.base, want.base);
            if (rsp_item.action != want.action) report("action", rsp_item.action, want.action);
            if (rsp_item.last != want.last) report("last", rsp_item.last, want.last);
         end
      end
   end

   // watchdog on cycles with no traffic at all
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic [7:0] random_symbol();
      case ($urandom_range(3))
         0: return 8'("ACGTacgt" >> (8 * $urandom_range(7)));
         1: return 8'($urandom_range(3));
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic add_item(input logic [1:0] mode, input logic [7:0] sym);
      req_type it;
      it.mode   = mode;
      it.symbol = sym;
      pending_items = {pending_items, it};
   endtask

   // a run: random loads in random order with stray unknown-mode items, then align
   task automatic add_run(input int la, input int lb);
      int na, nb;
      na = 0; nb = 0;
      while (na < la || nb < lb) begin
         if (nb >= lb || (na < la && $urandom_range(1))) begin
            add_item(MODE_LOAD_A, random_symbol()); na++;
         end else begin
            add_item(MODE_LOAD_B, random_symbol()); nb++;
         end
         if ($urandom_range(15) == 0) add_item(2'd3, 8'($urandom));
      end
      add_item(MODE_ALIGN, 8'($urandom));
   endtask

   task automatic drain();
      while (pending_items.size() > 0 || start || expected_edits.size() > 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_MISMATCH: mismatch_pen = int'($signed(val));
         CSR_GAP:      gap_pen      = int'($signed(val));
         default:      skew_pen     = int'($signed(val));
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [15:0] pick_penalty();
      case ($urandom_range(5))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         default: return 16'($signed($urandom_range(2048)) - 1024);
      endcase
   endfunction

   initial begin
      int total, phase;
      len_a = 0; len_b = 0;
      mismatch_pen = int'(MISMATCH_RESET);
      gap_pen      = int'(GAP_RESET);
      skew_pen     = int'(SKEW_RESET);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty run, all symbol spellings, unknown mode, identical pair, B only, A only
      add_item(MODE_ALIGN, 8'h00);
      add_item(MODE_LOAD_A, "A"); add_item(MODE_LOAD_A, "c"); add_item(MODE_LOAD_A, 8'd2);
      add_item(MODE_LOAD_A, "t"); add_item(MODE_LOAD_A, 8'hff);
      add_item(MODE_LOAD_B, "a"); add_item(MODE_LOAD_B, "C"); add_item(MODE_LOAD_B, "g");
      add_item(MODE_LOAD_B, "T"); add_item(MODE_LOAD_B, 8'd3); add_item(MODE_LOAD_B, "G");
      add_item(2'd3, 8'hff);
      add_item(MODE_ALIGN, 8'hff);
      add_item(MODE_LOAD_A, 8'd1); add_item(MODE_LOAD_A, "g");
      add_item(MODE_LOAD_B, "C"); add_item(MODE_LOAD_B, 8'd2);
      add_item(MODE_ALIGN, 8'h00);
      add_item(MODE_LOAD_B, 8'd1); add_item(MODE_LOAD_B, "A");  // B only: inserts
      add_item(MODE_ALIGN, 8'h00);
      add_item(MODE_LOAD_A, "T"); add_item(MODE_LOAD_A, "a");   // A only: deletes
      add_item(MODE_ALIGN, 8'h00);
      total = 25;
      drain();

      // phases with fresh penalties, extremes first
      for (phase = 0; total < ITEM_TARGET; phase++) begin
         if (phase == 0) begin
            write_csr(CSR_MISMATCH, 16'h7fff); write_csr(CSR_GAP, 16'h8000);
            write_csr(CSR_SKEW, 16'h7fff);
         end else if (phase == 1) begin
            write_csr(CSR_MISMATCH, 16'h8000); write_csr(CSR_GAP, 16'h7fff);
            write_csr(CSR_SKEW, 16'h8000);
         end else begin
            write_csr(CSR_MISMATCH, pick_penalty()); write_csr(CSR_GAP, pick_penalty());
            write_csr(CSR_SKEW, pick_penalty());
         end
         repeat (4) begin
            int la, lb;
            // mostly short runs; now and then a long one, up to two symbols past capacity
            if ($urandom_range(9) == 0) begin
               la = $urandom_range(34, 30); lb = $urandom_range(34, 28);
            end else begin
               la = $urandom_range(6); lb = $urandom_range(6);
            end
            add_run(la, lb);
            total += la + lb + 1;
         end
         drain();
      end

      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
